// File: sv/byte_to_5bit_symbol_codec_defines.svh
// assertion macros shared by the codec rtl
`ifndef BYTE_TO_5BIT_SYMBOL_CODEC_DEFINES_SVH
`define BYTE_TO_5BIT_SYMBOL_CODEC_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define B5S_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b5s assertion failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define B5S_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b5s assertion failed");

`endif

// File: sv/b5s_pkg.sv
// shared constants, types and the symbol alphabet of the 5-bit symbol codec
package b5s_pkg;

    // payload widths
    localparam int BYTE_W     = 8;
    localparam int SYM_W      = 5;
    localparam int LINE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int MAX_RES    = 5;

    // character codes and alphabet constants
    localparam logic [BYTE_W-1:0] NL_CHAR      = 8'd10;
    localparam logic [BYTE_W-1:0] LETTER_BASE  = 8'd65;
    localparam logic [BYTE_W-1:0] DIGIT_OFFSET = 8'd22;
    localparam logic [SYM_W-1:0]  LETTER_SPAN  = 5'd26;
    localparam logic [LINE_W-1:0] COUNT_MAX    = 7'd127;
    localparam logic [LINE_W-1:0] LIMIT_RST    = 7'd72;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_LIMIT = 2'd1
    } t_cfg_idx;

    // 5-bit value to its character: letters first, then digits
    function automatic logic [BYTE_W-1:0] symbol_of(input logic [SYM_W-1:0] v);
        logic [BYTE_W-1:0] ch;
        if (v < LETTER_SPAN) begin
            ch = LETTER_BASE + {3'b000, v};
        end else begin
            ch = DIGIT_OFFSET + {3'b000, v};
        end
        return ch;
    endfunction

endpackage

// File: sv/b5s_in_if.sv
// input word channel: one byte and its end-of-stream flag
interface b5s_in_if;
    logic                         valid;
    logic                         ready;
    logic [b5s_pkg::BYTE_W-1:0]   in_byte;
    logic                         end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// File: sv/b5s_out_if.sv
// output word channel: one character and its last flag
interface b5s_out_if;
    logic                         valid;
    logic                         ready;
    logic [b5s_pkg::BYTE_W-1:0]   out_char;
    logic                         last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// File: sv/b5s_cfg_if.sv
// configuration write channel: register index and write data
interface b5s_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [b5s_pkg::CFG_IDX_W-1:0]    index;
    logic [b5s_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/byte_to_5bit_symbol_codec.sv
// Byte to 5-bit symbol codec. In encode mode (mode = 1, the reset value) each input byte is
// split MSB-first into 5-bit symbols written as 'A'-'Z' and '0'-'5', with a newline after
// line_limit symbols per line; at end_of_stream any leftover bits are padded into one last symbol
// closed by a newline. In decode mode (mode = 0) newlines are skipped and symbols are packed
// back into bytes; leftover bits at end_of_stream are dropped. A word is taken into an input
// register, then its whole result list (0 to 5 characters) is worked out and loaded into a
// result shift register once that register is empty or is handing out its last character;
// it sends one character per cycle while the receiver is ready, the last one flagged. A new
// word is accepted whenever the input register is empty or its word moves on, so the next word
// can come in while the results of the last are still going out. A normal encode word gives
// one or two symbols and a possible newline, a decode word at most one byte, a flushing
// end-of-stream word up to five characters. Writing mode clears the pending bits and the line
// count; configuration is taken at any time, but is only meant to change while the block is
// idle.
`include "byte_to_5bit_symbol_codec_defines.svh"

module byte_to_5bit_symbol_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b5s_in_if.sink     i_in,
    b5s_out_if.source  o_out,
    b5s_cfg_if.sink    i_cfg
);

    // configuration
    logic                              r_mode;
    logic [b5s_pkg::LINE_W-1:0]        r_limit;

    // codec state
    logic [6:0]                        r_buf;
    logic [2:0]                        r_bcnt;
    logic [b5s_pkg::LINE_W-1:0]        r_line;

    // input register
    logic                              r_in_valid;
    logic [b5s_pkg::BYTE_W-1:0]        r_in_byte;
    logic                              r_in_eos;

    // result shift register
    logic [b5s_pkg::BYTE_W-1:0]        r_list [b5s_pkg::MAX_RES];
    logic [2:0]                        r_left;

    // next values
    logic [b5s_pkg::BYTE_W-1:0]        n_list [b5s_pkg::MAX_RES];
    logic [2:0]                        n_num;
    logic [6:0]                        n_buf;
    logic [2:0]                        n_bcnt;
    logic [b5s_pkg::LINE_W-1:0]        n_line;

    // handshake
    logic                              w_take;
    logic                              w_consume;
    logic                              w_accept;
    logic                              w_mode_wr;

    // encode datapath
    logic [2:0]                        e_cnt;
    logic [11:0]                       e_acc;
    logic [3:0]                        e_tot;
    logic                              e_two;
    logic [2:0]                        e_rem;
    logic [b5s_pkg::SYM_W-1:0]         e_s1;
    logic [b5s_pkg::SYM_W-1:0]         e_s2;
    logic [3:0]                        e_left;
    logic [7:0]                        e_lc;
    logic [b5s_pkg::LINE_W-1:0]        e_lcs;
    logic                              e_nl;
    logic [b5s_pkg::LINE_W-1:0]        e_lc2;
    logic                              e_flush;
    logic [7:0]                        e_lcf;
    logic                              e_nl2;
    logic [b5s_pkg::SYM_W-1:0]         e_pad;

    // decode datapath
    logic                              d_isnl;
    logic [b5s_pkg::SYM_W-1:0]         d_v;
    logic [11:0]                       d_acc;
    logic [3:0]                        d_tot;
    logic                              d_emit;
    logic [2:0]                        d_rem;
    logic [b5s_pkg::BYTE_W-1:0]        d_byte;
    logic [6:0]                        d_left;

    // list builder
    logic [2:0]                        k;

    // handshake decode
    assign w_take    = o_out.valid && o_out.ready;
    assign w_consume = r_in_valid && ((r_left == 3'd0) || ((r_left == 3'd1) && o_out.ready));
    assign w_accept  = i_in.valid && i_in.ready;
    assign w_mode_wr = i_cfg.valid && i_cfg.ready && (i_cfg.index == b5s_pkg::CFG_MODE);
    assign i_in.ready  = !r_in_valid || w_consume;
    assign i_cfg.ready = 1'b1;

    // output port
    assign o_out.valid    = (r_left != 3'd0);
    assign o_out.out_char = r_list[0];
    assign o_out.last     = (r_left == 3'd1);

    // encode: append the byte, split off one or two symbols, line and flush handling
    always_comb begin
        e_cnt   = (r_bcnt > 3'd4) ? 3'd4 : r_bcnt;
        e_acc   = {r_buf[3:0] & 4'((5'd1 << e_cnt) - 5'd1), r_in_byte};
        e_tot   = {1'b0, e_cnt} + 4'd8;
        e_two   = (e_tot >= 4'd10);
        e_rem   = e_two ? 3'(e_tot - 4'd10) : 3'(e_tot - 4'd5);
        e_s1    = 5'(e_acc >> (e_tot - 4'd5));
        e_s2    = 5'(e_acc >> e_rem);
        e_left  = 4'(e_acc & 12'((13'd1 << e_rem) - 13'd1));
        e_lc    = {1'b0, r_line} + (e_two ? 8'd2 : 8'd1);
        e_lcs   = (e_lc > {1'b0, b5s_pkg::COUNT_MAX}) ? b5s_pkg::COUNT_MAX : e_lc[6:0];
        e_nl    = (e_lcs >= r_limit);
        e_lc2   = e_nl ? '0 : e_lcs;
        e_flush = r_in_eos && (e_rem != 3'd0);
        e_lcf   = {1'b0, e_lc2} + 8'd1;
        e_nl2   = (e_lcf >= {1'b0, r_limit}) && !e_nl;
        e_pad   = 5'({1'b0, e_left} << (3'd5 - e_rem));
    end

    // decode: map the character, append five bits, split off a byte when one is full
    always_comb begin
        d_isnl = (r_in_byte == b5s_pkg::NL_CHAR);
        d_v    = (r_in_byte >= b5s_pkg::LETTER_BASE) ? 5'(r_in_byte - b5s_pkg::LETTER_BASE)
                                                     : 5'(r_in_byte - b5s_pkg::DIGIT_OFFSET);
        d_acc  = {r_buf & 7'((8'd1 << r_bcnt) - 8'd1), d_v};
        d_tot  = {1'b0, r_bcnt} + 4'd5;
        d_emit = (d_tot >= 4'd8);
        d_rem  = d_emit ? 3'(d_tot - 4'd8) : 3'(d_tot);
        d_byte = 8'(d_acc >> (d_tot - 4'd8));
        d_left = 7'(d_acc & 12'((13'd1 << d_rem) - 13'd1));
    end

    // result list and next state for the word in the input register
    always_comb begin
        k = 3'd0;
        for (int i = 0; i < b5s_pkg::MAX_RES; i++) begin
            n_list[i] = '0;
        end
        n_buf  = r_buf;
        n_bcnt = r_bcnt;
        n_line = r_line;
        if (r_mode) begin
            n_list[k] = b5s_pkg::symbol_of(e_s1);
            k = k + 3'd1;
            if (e_two) begin
                n_list[k] = b5s_pkg::symbol_of(e_s2);
                k = k + 3'd1;
            end
            if (e_nl) begin
                n_list[k] = b5s_pkg::NL_CHAR;
                k = k + 3'd1;
            end
            if (e_flush) begin
                if (e_nl2) begin
                    n_list[k] = b5s_pkg::NL_CHAR;
                    k = k + 3'd1;
                end
                n_list[k] = b5s_pkg::symbol_of(e_pad);
                k = k + 3'd1;
                n_list[k] = b5s_pkg::NL_CHAR;
                k = k + 3'd1;
            end
            n_buf  = {3'b000, e_left};
            n_bcnt = e_rem;
            n_line = e_lc2;
        end else begin
            if (!d_isnl) begin
                if (d_emit) begin
                    n_list[k] = d_byte;
                    k = k + 3'd1;
                end
                n_buf  = d_left;
                n_bcnt = d_rem;
            end
        end
        if (r_in_eos) begin
            n_buf  = '0;
            n_bcnt = '0;
            n_line = '0;
        end
        // a mode write clears the pending bits and the line count
        if (w_mode_wr) begin
            n_buf  = '0;
            n_bcnt = '0;
            n_line = '0;
        end
        n_num = k;
    end

    // control registers: configuration, state, input valid, result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b1;
            r_limit    <= b5s_pkg::LIMIT_RST;
            r_buf      <= '0;
            r_bcnt     <= '0;
            r_line     <= '0;
            r_in_valid <= 1'b0;
            r_left     <= '0;
        end else begin
            if (w_consume || w_mode_wr) begin
                r_buf  <= n_buf;
                r_bcnt <= n_bcnt;
                r_line <= n_line;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    b5s_pkg::CFG_MODE: begin
                        r_mode <= i_cfg.data[0];
                    end
                    b5s_pkg::CFG_LIMIT: begin
                        r_limit <= i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_consume) begin
                r_in_valid <= 1'b0;
            end
            if (w_consume) begin
                r_left <= n_num;
            end else if (w_take) begin
                r_left <= r_left - 3'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in.in_byte;
            r_in_eos  <= i_in.end_of_stream;
        end
        if (w_consume) begin
            r_list <= n_list;
        end else if (w_take) begin
            for (int i = 0; i < b5s_pkg::MAX_RES - 1; i++) begin
                r_list[i] <= r_list[i+1];
            end
        end
    end

    // every encoded word gives at least one symbol
    `B5S_ASSERT_IMPL(a_enc_gives_result, w_consume && r_mode, n_num != 3'd0)
    // results of one word go out without a gap
    `B5S_ASSERT_NEXT(a_burst_no_gap, w_take && !o_out.last, o_out.valid)
    // a word waiting in the input register is held
    `B5S_ASSERT_NEXT(a_word_held, r_in_valid && !w_consume, r_in_valid && $stable(r_in_byte))
    // encode never leaves more than four pending bits
    `B5S_ASSERT_NEXT(a_enc_leftover, w_consume && r_mode && !r_in_eos, r_bcnt <= 3'd4)

endmodule

// File: test/symbol_stream_checker.sv
// checker for the 5-bit symbol codec: predicts every output word and compares it
`timescale 1ns / 100ps

module symbol_stream_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    b5s_in_if    i_in_ch,
    b5s_out_if   i_out_ch,
    b5s_cfg_if   i_cfg_ch,
    output int   o_errors,
    output int   o_pending
);

    localparam logic                       MODE_RST   = 1'b1;
    localparam logic [b5s_pkg::BYTE_W-1:0] DIGIT_ZERO = "0";

    typedef struct packed {
        logic [b5s_pkg::BYTE_W-1:0] out_char;
        logic                       last;
    } t_char_word;

    // output words still owed by the block, oldest first
    t_char_word expected_chars[$];

    // shadow registers and pending bits of the codec
    logic                       mode_enc;
    logic [b5s_pkg::LINE_W-1:0] line_limit;
    logic [11:0]                bit_buf;
    logic [3:0]                 bit_cnt;
    logic [b5s_pkg::LINE_W-1:0] line_cnt;

    // 5-bit value to its character: letters, then digits
    function automatic logic [b5s_pkg::BYTE_W-1:0] char_of_value(input int v);
        int code;
        code = v & 31;
        if (code < b5s_pkg::LETTER_SPAN) begin
            return 8'(b5s_pkg::LETTER_BASE + code);
        end
        return 8'(DIGIT_ZERO + code - b5s_pkg::LETTER_SPAN);
    endfunction

    task automatic clear_pending();
        bit_buf  = '0;
        bit_cnt  = '0;
        line_cnt = '0;
    endtask

    // work out the output words caused by one input word
    task automatic predict_words(input logic [b5s_pkg::BYTE_W-1:0] c, input logic eos);
        int         nbits;
        int         acc;
        int         col;
        int         v;
        bit         nl_done;
        t_char_word batch[$];

        nl_done = 1'b0;
        if (mode_enc) begin
            nbits = (bit_cnt > 4) ? 4 : bit_cnt;
            acc   = ((bit_buf & ((1 << nbits) - 1)) << 8) | c;
            nbits += 8;
            col   = line_cnt;
            while (nbits >= 5) begin
                nbits -= 5;
                batch.push_back({char_of_value(acc >> nbits), 1'b0});
                col++;
            end
            acc &= (1 << nbits) - 1;
            if (col > b5s_pkg::COUNT_MAX) begin
                col = b5s_pkg::COUNT_MAX;
            end
            // line full after this word
            if (col >= line_limit) begin
                batch.push_back({b5s_pkg::NL_CHAR, 1'b0});
                col     = 0;
                nl_done = 1'b1;
            end
            if (eos) begin
                // pad leftover bits, one more line check, closing newline
                if (nbits > 0) begin
                    col++;
                    if (col >= line_limit && !nl_done) begin
                        batch.push_back({b5s_pkg::NL_CHAR, 1'b0});
                    end
                    batch.push_back({char_of_value(acc << (5 - nbits)), 1'b0});
                    batch.push_back({b5s_pkg::NL_CHAR, 1'b0});
                end
                clear_pending();
            end else begin
                bit_buf  = 12'(acc);
                bit_cnt  = 4'(nbits);
                line_cnt = 7'(col);
            end
        end else begin
            // newlines are skipped, anything else carries 5 bits
            if (c != b5s_pkg::NL_CHAR) begin
                v     = ((c >= b5s_pkg::LETTER_BASE) ? c - b5s_pkg::LETTER_BASE
                                                     : c - b5s_pkg::DIGIT_OFFSET) & 31;
                nbits = (bit_cnt > 7) ? 7 : bit_cnt;
                acc   = ((bit_buf & ((1 << nbits) - 1)) << 5) | v;
                nbits += 5;
                if (nbits >= 8) begin
                    nbits -= 8;
                    batch.push_back({8'(acc >> nbits), 1'b0});
                    acc &= (1 << nbits) - 1;
                end
                bit_buf = 12'(acc);
                bit_cnt = 4'(nbits);
            end
            if (eos) begin
                clear_pending();
            end
        end

        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[k]) begin
            expected_chars.push_back(batch[k]);
        end
    endtask

    // watch the three channels on every rising edge
    always @(posedge i_clk) begin
        t_char_word want;
        if (!i_rst_n) begin
            mode_enc   = MODE_RST;
            line_limit = b5s_pkg::LIMIT_RST;
            clear_pending();
            expected_chars.delete();
            o_errors   = 0;
        end else begin
            // compare an accepted output word with the oldest expectation
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_chars.size() == 0) begin
                    o_errors++;
                    $display("%0t: expected no word, actual char %0d last %0b",
                             $time, i_out_ch.out_char, i_out_ch.last);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_ch.out_char !== want.out_char || i_out_ch.last !== want.last) begin
                        o_errors++;
                        $display("%0t: expected char %0d last %0b, actual char %0d last %0b",
                                 $time, want.out_char, want.last,
                                 i_out_ch.out_char, i_out_ch.last);
                    end
                end
            end
            // register writes
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                unique case (b5s_pkg::t_cfg_idx'(i_cfg_ch.index))
                    b5s_pkg::CFG_MODE: begin
                        mode_enc = i_cfg_ch.data[0];
                        clear_pending();
                    end
                    b5s_pkg::CFG_LIMIT: begin
                        line_limit = i_cfg_ch.data;
                    end
                    default: begin
                    end
                endcase
            end
            // accepted input word
            if (i_in_ch.valid && i_in_ch.ready) begin
                predict_words(i_in_ch.in_byte, i_in_ch.end_of_stream);
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

// File: test/byte_to_5bit_symbol_codec_test.sv
// testbench top for the 5-bit symbol codec: stimulus, flow control and verdict
`timescale 1ns / 100ps

module byte_to_5bit_symbol_codec_test;

    localparam logic                          MODE_DECODE   = 1'b0;
    localparam logic                          MODE_ENCODE   = 1'b1;
    localparam logic [b5s_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int                            SETTLE_CYCLES = 8;
    localparam logic [b5s_pkg::BYTE_W-1:0]    DIGIT_ZERO    = "0";

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_COMB,
        RX_SLOW
    } t_rx_style;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    int        n_errors;
    int        n_pending;
    int        burst_left = 0;
    int        rx_left    = 0;
    int        rx_tick    = 0;
    t_rx_style rx_style   = RX_OPEN;

    b5s_in_if  in_ch();
    b5s_out_if out_ch();
    b5s_cfg_if cfg_ch();

    byte_to_5bit_symbol_codec u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    symbol_stream_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_ch   (in_ch),
        .i_out_ch  (out_ch),
        .i_cfg_ch  (cfg_ch),
        .o_errors  (n_errors),
        .o_pending (n_pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure; a new style is drawn each time rx_left runs down to zero
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        rx_tick++;
        unique case (rx_style)
            RX_OPEN: out_ch.ready = 1'b1;
            RX_COIN: out_ch.ready = 1'($urandom_range(0, 1));
            RX_COMB: out_ch.ready = (rx_tick % 3) != 0;
            default: out_ch.ready = ($urandom_range(0, 5) == 0);
        endcase
    end

    // one input word, then the sender's burst and gap pacing
    task automatic send_word(input logic [b5s_pkg::BYTE_W-1:0] c, input logic eos);
        @(negedge i_clk);
        in_ch.valid         = 1'b1;
        in_ch.in_byte       = c;
        in_ch.end_of_stream = eos;
        do @(posedge i_clk); while (!in_ch.ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // hold off until every owed word is out and the block has settled
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [b5s_pkg::CFG_IDX_W-1:0] idx,
                             input logic [b5s_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic configure(input logic mode, input logic [b5s_pkg::LINE_W-1:0] limit);
        wait_drained();
        write_reg(b5s_pkg::CFG_LIMIT, limit);
        write_reg(b5s_pkg::CFG_MODE, {{(b5s_pkg::CFG_DATA_W - 1){1'b0}}, mode});
    endtask

    // decode stimulus: mostly alphabet symbols, some newlines and noise
    function automatic logic [b5s_pkg::BYTE_W-1:0] pick_symbol();
        int pick;
        int v;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return b5s_pkg::NL_CHAR;
        end
        if (pick == 1) begin
            return 8'($urandom_range(0, 255));
        end
        v = $urandom_range(0, 31);
        return (v < b5s_pkg::LETTER_SPAN) ? 8'(b5s_pkg::LETTER_BASE + v)
                                          : 8'(DIGIT_ZERO + v - b5s_pkg::LETTER_SPAN);
    endfunction

    // random streams under one setting
    task automatic run_phase(input logic mode, input logic [b5s_pkg::LINE_W-1:0] limit,
                             input int n_words);
        int                         counted;
        int                         len;
        logic [b5s_pkg::BYTE_W-1:0] c;
        logic                       eos;
        configure(mode, limit);
        counted = 0;
        while (counted < n_words) begin
            len = $urandom_range(1, 24);
            for (int k = 0; k < len; k++) begin
                eos = (k == len - 1) && ($urandom_range(0, 4) != 0);
                c   = (mode == MODE_ENCODE) ? 8'($urandom_range(0, 255)) : pick_symbol();
                send_word(c, eos);
                if (mode == MODE_ENCODE || c != b5s_pkg::NL_CHAR) begin
                    counted++;
                end
                if ($urandom_range(0, 79) == 0) begin
                    wait_drained();
                end
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.end_of_stream = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = b5s_pkg::CFG_MODE;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // one symbol per line: newline after every word, empty line dropped on flush
        configure(MODE_ENCODE, 7'd1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b1);
        send_word(8'h80, 1'b1);
        send_word(8'h3C, 1'b0);

        // widest line; mode write drops the bits left above; stream ends on a group edge
        configure(MODE_ENCODE, 7'd127);
        send_word(8'h00, 1'b0);
        send_word(8'h44, 1'b0);
        send_word(8'h32, 1'b0);
        send_word(8'h14, 1'b0);
        send_word(8'hC7, 1'b1);

        // zero line limit fires on every word
        configure(MODE_ENCODE, 7'd0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b1);

        // a write to an unused index changes nothing
        wait_drained();
        write_reg(CFG_IDX_SPARE, 7'h55);

        // decode: letter and digit extremes, skipped newline, odd bytes, dropped tail
        configure(MODE_DECODE, 7'd72);
        send_word(b5s_pkg::LETTER_BASE, 1'b0);
        send_word("Z", 1'b0);
        send_word(DIGIT_ZERO, 1'b0);
        send_word("5", 1'b0);
        send_word(b5s_pkg::NL_CHAR, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word("B", 1'b1);

        // random streams over a spread of settings
        run_phase(MODE_ENCODE, 7'd1, 50);
        run_phase(MODE_ENCODE, 7'd127, 65);
        run_phase(MODE_DECODE, 7'($urandom_range(1, 127)), 75);
        run_phase(MODE_ENCODE, 7'($urandom_range(2, 12)), 65);
        run_phase(MODE_DECODE, 7'd5, 50);
        run_phase(MODE_ENCODE, 7'd72, 65);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("PASS byte_to_5bit_symbol_codec");
        end else begin
            $display("FAIL byte_to_5bit_symbol_codec");
        end
        $finish;
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("FAIL byte_to_5bit_symbol_codec");
        $finish;
    end

endmodule
